// File: hw/rtl/tcsp_pkg.sv
// ----------------------------------------------------------------------------
// tcsp_pkg
// Shared types and codes for the telnet command stream parser.
// ----------------------------------------------------------------------------
package tcsp_pkg;

    localparam logic [7:0] B_NUL  = 8'd0;
    localparam logic [7:0] B_LF   = 8'd10;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_IAC  = 8'd255;

    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] OPT_TSPD  = 8'd32;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_WINDOW = 2'd2;

    localparam logic [15:0] RESET_COLS = 16'd80;
    localparam logic [15:0] RESET_ROWS = 16'd25;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0]       count;
        res_t [2:0]       item;
        logic [15:0]      cols;
        logic [15:0]      rows;
    } burst_t;

endpackage

// File: hw/rtl/tcsp_in_skid.sv
// ----------------------------------------------------------------------------
// tcsp_in_skid
// Input register with a skid slot; stall is taken straight from a register.
// ----------------------------------------------------------------------------
module tcsp_in_skid
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       main_valid,
    output logic [7:0] main_byte
);

    logic       main_valid_reg;
    logic [7:0] main_byte_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_byte_reg;
    logic       in_fire;

    assign in_stall   = skid_valid_reg;
    assign in_fire    = in_valid && !skid_valid_reg;
    assign main_valid = main_valid_reg;
    assign main_byte  = main_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            if (!main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_byte_reg <= skid_byte_reg;
            end
            else
            begin
                main_byte_reg <= rx_byte;
            end
        end
        else if (in_fire)
        begin
            if (!main_valid_reg)
            begin
                main_byte_reg <= rx_byte;
            end
            else
            begin
                skid_byte_reg <= rx_byte;
            end
        end
    end

endmodule

// File: hw/rtl/tcsp_parser.sv
// ----------------------------------------------------------------------------
// tcsp_parser
// Telnet parse state and the decode of one byte into a burst of results.
// ----------------------------------------------------------------------------
module tcsp_parser
    import tcsp_pkg::*;
#(
    parameter int OPTION_STORE = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output burst_t     burst
);

    localparam int CW = $clog2(OPTION_STORE + 1);

    localparam logic [2:0] ST_NORMAL = 3'd0;
    localparam logic [2:0] ST_IAC    = 3'd1;
    localparam logic [2:0] ST_OPT    = 3'd2;
    localparam logic [2:0] ST_SB     = 3'd3;
    localparam logic [2:0] ST_OPTDAT = 3'd4;
    localparam logic [2:0] ST_SE     = 3'd5;

    logic [2:0]    state_reg,   state_next;
    logic [7:0]    cmd_reg,     cmd_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [7:0]    opt_reg [4];
    logic          opt_we;
    logic [15:0]   cols_reg,    cols_next;
    logic [15:0]   rows_reg,    rows_next;
    logic          prev_cr_reg;
    logic [7:0]    c;
    logic [7:0]    reply_code;
    logic          reply_none;
    logic [15:0]   naws_cols;
    logic [15:0]   naws_rows;

    assign c = (rx_byte == B_NUL && prev_cr_reg) ? B_LF : rx_byte;
    assign naws_cols = {opt_reg[0], opt_reg[1]};
    assign naws_rows = {opt_reg[2], opt_reg[3]};

    always_comb
    begin
        reply_none = (c == OPT_ECHO) || (c == OPT_SGA) || (c == OPT_NAWS);
        if (c == OPT_TTYPE || c == OPT_TSPD)
        begin
            reply_code = B_DO;
        end
        else if (cmd_reg == B_WILL || cmd_reg == B_WONT)
        begin
            reply_code = B_DONT;
        end
        else
        begin
            reply_code = B_WONT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        opt_we     = 1'b0;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        burst.count = 2'd0;
        burst.item[0] = '{kind: KIND_DATA, value: c, last: 1'b1};
        burst.item[1] = '{kind: KIND_REPLY, value: reply_code, last: 1'b0};
        burst.item[2] = '{kind: KIND_REPLY, value: c, last: 1'b1};
        unique case (state_reg)
            ST_IAC:
            begin
                state_next = ST_NORMAL;
                if (c == B_IAC)
                begin
                    burst.count = 2'd1;
                end
                else if (c >= B_WILL && c <= B_DONT)
                begin
                    cmd_next   = c;
                    state_next = ST_OPT;
                end
                else if (c == B_SB)
                begin
                    state_next = ST_SB;
                end
            end
            ST_OPT:
            begin
                state_next = ST_NORMAL;
                burst.item[0] = '{kind: KIND_REPLY, value: B_IAC, last: 1'b0};
                if (!reply_none)
                begin
                    burst.count = 2'd3;
                end
            end
            ST_SB:
            begin
                cmd_next   = c;
                count_next = '0;
                state_next = ST_OPTDAT;
            end
            ST_OPTDAT:
            begin
                if (c == B_IAC)
                begin
                    state_next = ST_SE;
                end
                else if (count_reg < CW'(OPTION_STORE))
                begin
                    opt_we     = (count_reg < CW'(4));
                    count_next = count_reg + 1'b1;
                end
            end
            ST_SE:
            begin
                state_next = ST_NORMAL;
                if (c == B_SE && cmd_reg == OPT_NAWS && count_reg == CW'(4))
                begin
                    if (naws_cols != 16'd0)
                    begin
                        cols_next = naws_cols;
                    end
                    if (naws_rows != 16'd0)
                    begin
                        rows_next = naws_rows;
                    end
                    burst.count = 2'd1;
                    burst.item[0] = '{kind: KIND_WINDOW, value: 8'd0, last: 1'b1};
                end
            end
            default:
            begin
                if (c == B_IAC)
                begin
                    state_next = ST_IAC;
                end
                else
                begin
                    state_next  = ST_NORMAL;
                    burst.count = 2'd1;
                end
            end
        endcase
        burst.cols = cols_next;
        burst.rows = rows_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_NORMAL;
            cmd_reg     <= 8'd0;
            count_reg   <= '0;
            cols_reg    <= RESET_COLS;
            rows_reg    <= RESET_ROWS;
            prev_cr_reg <= 1'b0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            count_reg   <= count_next;
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            prev_cr_reg <= (rx_byte == B_CR);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && opt_we)
        begin
            opt_reg[count_reg[1:0]] <= c;
        end
    end

endmodule

// File: hw/rtl/tcsp_burst.sv
// ----------------------------------------------------------------------------
// tcsp_burst
// Result register holding up to three results; sends them one per transfer.
// ----------------------------------------------------------------------------
module tcsp_burst
    import tcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_req,
    output logic        load_ok,
    input  burst_t      burst,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  value,
    output logic [15:0] window_cols,
    output logic [15:0] window_rows,
    output logic        last
);

    logic [1:0]  cnt_reg;
    res_t [2:0]  item_reg;
    logic [15:0] cols_reg;
    logic [15:0] rows_reg;
    logic        out_fire;
    logic        load;

    assign out_valid   = (cnt_reg != 2'd0);
    assign out_fire    = out_valid && !out_stall;
    assign load_ok     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_fire);
    assign load        = load_req && load_ok;
    assign kind        = item_reg[0].kind;
    assign value       = item_reg[0].value;
    assign last        = item_reg[0].last;
    assign window_cols = cols_reg;
    assign window_rows = rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= burst.count;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= burst.item;
            cols_reg <= burst.cols;
            rows_reg <= burst.rows;
        end
        else if (out_fire)
        begin
            item_reg[0] <= item_reg[1];
            item_reg[1] <= item_reg[2];
        end
    end

endmodule

// File: hw/rtl/telnet_command_stream_parser.sv
// ----------------------------------------------------------------------------
// telnet_command_stream_parser
// Telnet receive parser: data pass-through, option replies, NAWS updates.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  rx_byte
//  out      out_valid/ out_stall kind, value, window_cols, window_rows, last
//
//  One byte per cycle while neither side stalls; a byte passes the input register, then the result register.
//  An option reply holds the result register for three output transfers,
//  so input stalls once the skid slot fills behind it.
//  Stall on the input comes from a register (skid slot full).
//  Reset returns to the normal data state with an 80 x 25 window.
// ----------------------------------------------------------------------------
module telnet_command_stream_parser
    import tcsp_pkg::*;
#(
    parameter int OPTION_STORE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  value,
    output logic [15:0] window_cols,
    output logic [15:0] window_rows,
    output logic        last
);

    logic       main_valid;
    logic [7:0] main_byte;
    logic       load_ok;
    logic       fire;
    burst_t     burst;

    assign fire = main_valid && load_ok;

    tcsp_in_skid u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .take       (fire),
        .main_valid (main_valid),
        .main_byte  (main_byte)
    );

    tcsp_parser #(.OPTION_STORE(OPTION_STORE)) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (main_byte),
        .burst   (burst)
    );

    tcsp_burst u_burst
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_req    (main_valid),
        .load_ok     (load_ok),
        .burst       (burst),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .window_cols (window_cols),
        .window_rows (window_rows),
        .last        (last)
    );

endmodule

// File: hw/rtl/tcsp_checker.sv
// ----------------------------------------------------------------------------
// tcsp_checker
// Port-level checks for the telnet command stream parser.
// ----------------------------------------------------------------------------
module tcsp_checker
    import tcsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  value,
    input logic [15:0] window_cols,
    input logic [15:0] window_rows,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
            && $stable(last) && $stable(window_cols) && $stable(window_rows))
        else $error("stalled output transfer changed");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_DATA || kind == KIND_REPLY || kind == KIND_WINDOW)
        else $error("bad result kind");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DATA || kind == KIND_WINDOW) |-> last)
        else $error("data or window result not last");

    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WINDOW |-> value == 8'd0
            && window_cols != 16'd0 && window_rows != 16'd0)
        else $error("bad window update");

    a_reply_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_REPLY && value == B_IAC && !last
            |=> out_valid && kind == KIND_REPLY && !last)
        else $error("reply burst broken");

endmodule

bind telnet_command_stream_parser tcsp_checker u_tcsp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .value       (value),
    .window_cols (window_cols),
    .window_rows (window_rows),
    .last        (last)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telnet command stream parser. A directed byte
// table (data, CR NUL, IAC IAC, WILL/WONT/DO/DONT, NAWS, dropped command) is
// followed by random well-formed and broken command sequences and one
// oversized subnegotiation. Every result is checked against a local parser
// model under random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
    import tcsp_pkg::*;

    localparam int OPTION_STORE   = 256;
    localparam int DIR_ROWS       = 28;
    localparam int RANDOM_ITEMS   = 180;
    localparam int LONG_SUB_LEN   = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum logic [2:0] {
        PS_NORMAL,
        PS_IAC,
        PS_OPT,
        PS_SB,
        PS_OPTDAT,
        PS_SE
    } tn_state_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] cols;
        logic [15:0] rows;
        logic        last;
    } rx_result_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] cols;
        logic [15:0] rows;
    } rx_row_t;

    localparam rx_row_t DIRECTED_TBL [DIR_ROWS] = '{
        '{B_NUL,     1'b1, KIND_DATA,   8'h00, RESET_COLS, RESET_ROWS},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_IAC,     1'b1, KIND_DATA,   8'hFF, RESET_COLS, RESET_ROWS},
        '{B_CR,      1'b1, KIND_DATA,   8'h0D, RESET_COLS, RESET_ROWS},
        '{B_NUL,     1'b1, KIND_DATA,   B_LF,  RESET_COLS, RESET_ROWS},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_WILL,    1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{OPT_TTYPE, 1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_WONT,    1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'h07,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_DO,      1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'hC8,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_DONT,    1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{OPT_ECHO,  1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_SB,      1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{OPT_NAWS,  1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'h01,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'h00,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'h00,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'h00,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{B_SE,      1'b1, KIND_WINDOW, 8'h00, 16'd256,    RESET_ROWS},
        '{B_IAC,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0},
        '{8'hF1,     1'b0, KIND_DATA,   8'h00, 16'd0,      16'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] window_cols;
    logic [15:0] window_rows;
    logic        last;

    rx_row_t    rx_stream[$];
    rx_result_t pending_results[$];
    int         rx_accepted = 0;
    int         err_cnt = 0;
    int         idle_cycles = 0;

    // parser model state
    tn_state_e   tn_state = PS_NORMAL;
    logic [7:0]  tn_cmd = 8'h00;
    int          sub_count = 0;
    logic [7:0]  sub_bytes [4];
    logic [15:0] term_cols = RESET_COLS;
    logic [15:0] term_rows = RESET_ROWS;
    logic        after_cr = 1'b0;

    telnet_command_stream_parser #(
        .OPTION_STORE (OPTION_STORE)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .window_cols (window_cols),
        .window_rows (window_rows),
        .last        (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic add_result(input logic [1:0] k, input logic [7:0] v, input logic l);
        pending_results.push_back('{k, v, term_cols, term_rows, l});
    endtask

    task automatic add_reply(input logic [7:0] code, input logic [7:0] opt);
        add_result(KIND_REPLY, B_IAC, 1'b0);
        add_result(KIND_REPLY, code, 1'b0);
        add_result(KIND_REPLY, opt, 1'b1);
    endtask

    task automatic parse_rx_byte(input logic [7:0] raw, output int n);
        logic [7:0]  c;
        logic [15:0] nc;
        logic [15:0] nr;
        c = (raw == B_NUL && after_cr) ? B_LF : raw;
        after_cr = (raw == B_CR);
        n = 0;
        case (tn_state)
            PS_IAC:
            begin
                if (c == B_IAC)
                begin
                    add_result(KIND_DATA, c, 1'b1);
                    n = 1;
                    tn_state = PS_NORMAL;
                end
                else if (c >= B_WILL && c <= B_DONT)
                begin
                    tn_cmd = c;
                    tn_state = PS_OPT;
                end
                else if (c == B_SB)
                    tn_state = PS_SB;
                else
                    tn_state = PS_NORMAL;
            end
            PS_OPT:
            begin
                if (c == OPT_ECHO || c == OPT_SGA || c == OPT_NAWS)
                    n = 0;
                else
                begin
                    if (c == OPT_TTYPE || c == OPT_TSPD)
                        add_reply(B_DO, c);
                    else if (tn_cmd == B_WILL || tn_cmd == B_WONT)
                        add_reply(B_DONT, c);
                    else
                        add_reply(B_WONT, c);
                    n = 3;
                end
                tn_state = PS_NORMAL;
            end
            PS_SB:
            begin
                tn_cmd = c;
                sub_count = 0;
                tn_state = PS_OPTDAT;
            end
            PS_OPTDAT:
            begin
                if (c == B_IAC)
                    tn_state = PS_SE;
                else if (sub_count < OPTION_STORE)
                begin
                    if (sub_count < 4)
                        sub_bytes[sub_count] = c;
                    sub_count++;
                end
            end
            PS_SE:
            begin
                if (c == B_SE && tn_cmd == OPT_NAWS && sub_count == 4)
                begin
                    nc = {sub_bytes[0], sub_bytes[1]};
                    nr = {sub_bytes[2], sub_bytes[3]};
                    if (nc != 16'd0)
                        term_cols = nc;
                    if (nr != 16'd0)
                        term_rows = nr;
                    add_result(KIND_WINDOW, 8'h00, 1'b1);
                    n = 1;
                end
                tn_state = PS_NORMAL;
            end
            default:
            begin
                if (c == B_IAC)
                    tn_state = PS_IAC;
                else
                begin
                    add_result(KIND_DATA, c, 1'b1);
                    n = 1;
                    tn_state = PS_NORMAL;
                end
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_stream.push_back('{b, 1'b0, KIND_DATA, 8'h00, 16'd0, 16'd0});
    endtask

    function automatic logic [7:0] sub_data();
        return 8'($urandom_range(0, 254));
    endfunction

    // input transfers feed the model, output transfers are checked
    always @(posedge clk)
    begin : monitor
        int         n;
        rx_result_t exp_r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(rx_stream[rx_accepted].b, n);
                if (rx_stream[rx_accepted].typed)
                begin
                    repeat (n) void'(pending_results.pop_back());
                    pending_results.push_back('{rx_stream[rx_accepted].kind,
                                                rx_stream[rx_accepted].value,
                                                rx_stream[rx_accepted].cols,
                                                rx_stream[rx_accepted].rows, 1'b1});
                end
                rx_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d value %0d", kind, value);
                    err_cnt++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (kind !== exp_r.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", exp_r.kind, kind);
                        err_cnt++;
                    end
                    if (value !== exp_r.value)
                    begin
                        $error("value: expected %0d, actual %0d", exp_r.value, value);
                        err_cnt++;
                    end
                    if (window_cols !== exp_r.cols)
                    begin
                        $error("window_cols: expected %0d, actual %0d", exp_r.cols,
                               window_cols);
                        err_cnt++;
                    end
                    if (window_rows !== exp_r.rows)
                    begin
                        $error("window_rows: expected %0d, actual %0d", exp_r.rows,
                               window_rows);
                        err_cnt++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_r.last, last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // output side: random stall before each transfer
    initial
    begin
        int  hold;
        bit  out_fast;
        out_fast = 1'b0;
        forever
        begin
            hold = out_fast ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0)
                out_fast = !out_fast;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        int         gap;
        int         pick;
        int         len;
        int         long_len;
        bit         in_fast;
        bit         long_done;
        logic [7:0] b;

        in_fast = 1'b0;
        long_done = 1'b0;
        long_len = 0;

        for (int i = 0; i < DIR_ROWS; i++)
            rx_stream.push_back(DIRECTED_TBL[i]);

        while (rx_stream.size() < DIR_ROWS + RANDOM_ITEMS + long_len)
        begin
            if (!long_done && rx_stream.size() >= DIR_ROWS + RANDOM_ITEMS / 2)
            begin
                // oversized NAWS: count runs past four, no window update
                long_done = 1'b1;
                long_len = LONG_SUB_LEN + 5;
                queue_byte(B_IAC);
                queue_byte(B_SB);
                queue_byte(OPT_NAWS);
                repeat (LONG_SUB_LEN) queue_byte(8'($urandom_range(1, 254)));
                queue_byte(B_IAC);
                queue_byte(B_SE);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                len = $urandom_range(1, 6);
                repeat (len) queue_byte(sub_data());
            end
            else if (pick < 35)
            begin
                queue_byte(B_CR);
                if ($urandom_range(0, 1))
                    queue_byte(B_CR);
                queue_byte(B_NUL);
            end
            else if (pick < 40)
            begin
                queue_byte(B_IAC);
                queue_byte(B_IAC);
            end
            else if (pick < 60)
            begin
                queue_byte(B_IAC);
                queue_byte(8'(B_WILL + $urandom_range(0, 3)));
                case ($urandom_range(0, 5))
                    0: queue_byte(OPT_ECHO);
                    1: queue_byte(OPT_SGA);
                    2: queue_byte(OPT_TTYPE);
                    3: queue_byte(OPT_NAWS);
                    4: queue_byte(OPT_TSPD);
                    default: queue_byte(8'($urandom_range(0, 255)));
                endcase
            end
            else if (pick < 75)
            begin
                queue_byte(B_IAC);
                queue_byte(B_SB);
                queue_byte(OPT_NAWS);
                repeat (2)
                begin
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            queue_byte(8'h00);
                            queue_byte(8'h00);
                        end
                        1:
                        begin
                            queue_byte(8'h00);
                            queue_byte(sub_data());
                        end
                        default:
                        begin
                            queue_byte(sub_data());
                            queue_byte(sub_data());
                        end
                    endcase
                end
                queue_byte(B_IAC);
                queue_byte(B_SE);
            end
            else if (pick < 83)
            begin
                queue_byte(B_IAC);
                queue_byte(B_SB);
                queue_byte(8'($urandom_range(0, 255)));
                len = $urandom_range(0, 6);
                repeat (len) queue_byte(sub_data());
                queue_byte(B_IAC);
                queue_byte(B_SE);
            end
            else if (pick < 91)
            begin
                queue_byte(B_IAC);
                queue_byte(B_SB);
                queue_byte(OPT_NAWS);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        len = $urandom_range(0, 1) ? 3 : 5;
                        repeat (len) queue_byte(sub_data());
                        queue_byte(B_IAC);
                        queue_byte(B_SE);
                    end
                    1:
                    begin
                        // bad terminator after IAC
                        repeat (4) queue_byte(sub_data());
                        queue_byte(B_IAC);
                        b = 8'($urandom_range(0, 255));
                        queue_byte((b == B_SE) ? B_NUL : b);
                    end
                    default:
                    begin
                        repeat (2) queue_byte(sub_data());
                        queue_byte(B_IAC);
                        queue_byte(B_IAC);
                        queue_byte(sub_data());
                    end
                endcase
            end
            else if (pick < 96)
            begin
                queue_byte(B_IAC);
                queue_byte(8'($urandom_range(0, 255)));
            end
            else
                queue_byte(8'($urandom_range(0, 255)));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < rx_stream.size(); i++)
        begin
            gap = in_fast ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0)
                in_fast = !in_fast;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte <= rx_stream[i].b;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (rx_accepted != rx_stream.size() || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
